// ----- design/itt_pkg.sv -----
// Shared types and constants of the interval tick timer.
// No dependencies; compile first.
package itt_pkg;

    localparam int DATA_W            = 32;
    localparam int COUNTER_WIDTH_DEF = 24;
    localparam int PRESCALE_DIV_DEF  = 8;

    // input item kind codes
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // bus register addresses
    localparam logic [2:0] ADDR_CTRL    = 3'd0;
    localparam logic [2:0] ADDR_RELOAD  = 3'd1;
    localparam logic [2:0] ADDR_CURRENT = 3'd2;
    localparam logic [2:0] ADDR_WRAP    = 3'd3;
    localparam logic [2:0] ADDR_ELAPSED = 3'd4;

    // control register bit positions
    localparam int CTRL_RUN_BIT  = 0;
    localparam int CTRL_IRQ_BIT  = 1;
    localparam int CTRL_CCS_BIT  = 2;
    localparam int CTRL_ONE_BIT  = 3;
    localparam int CTRL_FLAG_BIT = 16;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_TICK,
        OP_READ,
        OP_WRITE
    } t_op;

    typedef enum logic [2:0] {
        REG_CTRL,
        REG_RELOAD,
        REG_CURRENT,
        REG_WRAP,
        REG_ELAPSED,
        REG_NONE
    } t_reg;

    typedef struct packed {
        t_op                op;
        t_reg               sel;
        logic [DATA_W-1:0]  data;
    } t_cmd;

endpackage

// ----- design/itt_in_if.sv -----
// Input channel of the interval tick timer: valid/ready plus item fields.
// Depends on nothing.
interface itt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  reg_addr;
    logic [31:0] write_data;

    modport source (output valid, output kind, output reg_addr, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input reg_addr, input write_data,
                    output ready);
endinterface

// ----- design/itt_out_if.sv -----
// Result channel of the interval tick timer: valid/ready plus result fields.
// Depends on nothing.
interface itt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        interrupt_request;
    logic        reached_zero;

    modport source (output valid, output read_data, output interrupt_request,
                    output reached_zero, input ready);
    modport sink   (input valid, input read_data, input interrupt_request,
                    input reached_zero, output ready);
endinterface

// ----- design/itt_front.sv -----
// Front end: classifies an input item into an operation and register select.
// Depends on itt_pkg.
module itt_front (
    input  logic [1:0]   i_kind,
    input  logic [2:0]   i_reg_addr,
    input  logic [31:0]  i_write_data,
    output itt_pkg::t_cmd o_cmd
);
    import itt_pkg::*;

    always_comb begin
        o_cmd.data = i_write_data;
        unique case (i_kind)
            KIND_TICK:  o_cmd.op = OP_TICK;
            KIND_READ:  o_cmd.op = OP_READ;
            KIND_WRITE: o_cmd.op = OP_WRITE;
            default:    o_cmd.op = OP_NOP;
        endcase
        unique case (i_reg_addr)
            ADDR_CTRL:    o_cmd.sel = REG_CTRL;
            ADDR_RELOAD:  o_cmd.sel = REG_RELOAD;
            ADDR_CURRENT: o_cmd.sel = REG_CURRENT;
            ADDR_WRAP:    o_cmd.sel = REG_WRAP;
            ADDR_ELAPSED: o_cmd.sel = REG_ELAPSED;
            default:      o_cmd.sel = REG_NONE;
        endcase
    end

endmodule

// ----- design/itt_queue.sv -----
// Two-entry command queue between front and back end.
// Depends on itt_pkg.
module itt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  itt_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output itt_pkg::t_cmd o_cmd
);
    import itt_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- design/itt_back.sv -----
// Back end: timer state, command execution and the registered result stage.
// Depends on itt_pkg and itt_out_if.
module itt_back #(
    parameter int COUNTER_WIDTH = itt_pkg::COUNTER_WIDTH_DEF,
    parameter int PRESCALE_DIV  = itt_pkg::PRESCALE_DIV_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  itt_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    itt_out_if.source     o_out
);
    import itt_pkg::*;

    localparam int              PW      = $clog2(PRESCALE_DIV);
    localparam logic [PW-1:0]   PH_LAST = PW'(PRESCALE_DIV - 1);
    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

    logic                     r_run, n_run;
    logic                     r_irq_en, n_irq_en;
    logic                     r_ccs, n_ccs;
    logic                     r_one, n_one;
    logic                     r_flag, n_flag;
    logic [COUNTER_WIDTH-1:0] r_reload, n_reload;
    logic [COUNTER_WIDTH-1:0] r_cur, n_cur;
    logic [PW-1:0]            r_phase, n_phase;
    logic [DATA_W-1:0]        r_wrap, n_wrap;

    // result stage
    logic              r_b_valid;
    logic [DATA_W-1:0] r_b_a, n_b_a;
    logic [DATA_W-1:0] r_b_b, n_b_b;
    logic              r_b_irq, n_b_irq;
    logic              r_b_zero, n_b_zero;

    logic              w_go;
    logic              w_step;
    logic [DATA_W-1:0] w_ctrl;
    logic [DATA_W-1:0] w_prod;
    logic [DATA_W-1:0] w_diff;

    assign w_go      = i_cmd_valid && (!r_b_valid || o_out.ready);
    assign o_cmd_pop = w_go;

    assign w_prod = r_wrap * DATA_W'(r_reload);
    assign w_diff = DATA_W'(r_reload) - DATA_W'(r_cur);

    always_comb begin
        w_ctrl                = '0;
        w_ctrl[CTRL_RUN_BIT]  = r_run;
        w_ctrl[CTRL_IRQ_BIT]  = r_irq_en;
        w_ctrl[CTRL_CCS_BIT]  = r_ccs;
        w_ctrl[CTRL_ONE_BIT]  = r_one;
        w_ctrl[CTRL_FLAG_BIT] = r_flag;
    end

    always_comb begin
        n_run    = r_run;
        n_irq_en = r_irq_en;
        n_ccs    = r_ccs;
        n_one    = r_one;
        n_flag   = r_flag;
        n_reload = r_reload;
        n_cur    = r_cur;
        n_phase  = r_phase;
        n_wrap   = r_wrap;
        n_b_a    = '0;
        n_b_b    = '0;
        n_b_irq  = 1'b0;
        n_b_zero = 1'b0;
        w_step   = 1'b0;
        unique case (i_cmd.op)
            OP_TICK: begin
                if (r_run) begin
                    if (r_ccs) begin
                        w_step = 1'b1;
                    end else if (r_phase == PH_LAST) begin
                        w_step  = 1'b1;
                        n_phase = '0;
                    end else begin
                        n_phase = r_phase + PW'(1);
                    end
                    if (w_step) begin
                        if (r_cur == '0) begin
                            n_cur = r_reload;
                        end else begin
                            n_cur = r_cur - CNT_ONE;
                            if (r_cur == CNT_ONE) begin
                                n_flag   = 1'b1;
                                n_wrap   = r_wrap + DATA_W'(1);
                                n_b_zero = 1'b1;
                                n_b_irq  = r_irq_en;
                                if (r_one) begin
                                    n_run    = 1'b0;
                                    n_irq_en = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            OP_READ: begin
                unique case (i_cmd.sel)
                    REG_CTRL: begin
                        n_b_a  = w_ctrl;
                        n_flag = 1'b0;
                    end
                    REG_RELOAD:  n_b_a = DATA_W'(r_reload);
                    REG_CURRENT: n_b_a = DATA_W'(r_cur);
                    REG_WRAP:    n_b_a = r_wrap;
                    REG_ELAPSED: begin
                        n_b_a = w_diff;
                        n_b_b = w_prod;
                    end
                    default: n_b_a = '0;
                endcase
            end
            OP_WRITE: begin
                unique case (i_cmd.sel)
                    REG_CTRL: begin
                        n_run    = i_cmd.data[CTRL_RUN_BIT];
                        n_irq_en = i_cmd.data[CTRL_IRQ_BIT];
                        n_ccs    = i_cmd.data[CTRL_CCS_BIT];
                        n_one    = i_cmd.data[CTRL_ONE_BIT];
                    end
                    REG_RELOAD:  n_reload = i_cmd.data[COUNTER_WIDTH-1:0];
                    REG_CURRENT: begin
                        n_cur  = '0;
                        n_flag = 1'b0;
                    end
                    REG_WRAP: n_wrap = i_cmd.data;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_irq_en  <= 1'b0;
            r_ccs     <= 1'b0;
            r_one     <= 1'b0;
            r_flag    <= 1'b0;
            r_reload  <= '0;
            r_cur     <= '0;
            r_phase   <= '0;
            r_wrap    <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_go) begin
                r_run     <= n_run;
                r_irq_en  <= n_irq_en;
                r_ccs     <= n_ccs;
                r_one     <= n_one;
                r_flag    <= n_flag;
                r_reload  <= n_reload;
                r_cur     <= n_cur;
                r_phase   <= n_phase;
                r_wrap    <= n_wrap;
                r_b_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_b_a    <= n_b_a;
            r_b_b    <= n_b_b;
            r_b_irq  <= n_b_irq;
            r_b_zero <= n_b_zero;
        end
    end

    // elapsed = difference + product, the add sits after the product register
    assign o_out.valid             = r_b_valid;
    assign o_out.read_data         = r_b_a + r_b_b;
    assign o_out.interrupt_request = r_b_irq;
    assign o_out.reached_zero      = r_b_zero;

    a_irq_implies_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_irq |-> r_b_zero)
        else $error("interrupt without reaching zero");

    a_one_shot_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && (i_cmd.op == OP_TICK) && n_b_zero && r_one |=> !r_run && !r_irq_en)
        else $error("one-shot did not stop the counter");

    a_flag_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_flag) |-> $past(w_go && n_b_zero))
        else $error("count flag set without a zero crossing");

endmodule

// ----- design/interval_tick_timer.sv -----
// Top level of the interval tick timer: front decode, command queue, back end.
// Depends on itt_pkg, itt_in_if, itt_out_if, itt_front, itt_queue, itt_back.
//
// Usage:
//   i_in carries one item per handshake: a core clock tick (kind 0), a bus
//   read (kind 1) or a bus write (kind 2) at reg_addr with write_data.
//   o_out returns exactly one result per item: read_data on reads (zero
//   otherwise), reached_zero when a tick moved the counter from one to zero,
//   interrupt_request when that happened with the interrupt enabled.
//   An accepted item is written into the queue; once it is at the head
//   and the output register is free, the back end pops it and registers
//   its result in the output register. The back end takes one item per
//   cycle while the output register is free or the receiver is ready, and
//   updates the whole timer state for each item; elapsed reads register
//   the wrap times reload product and add it in the output stage.
//   Reset clears all timer state (control bits, flag, reload, count,
//   prescaler phase, wrap count) and empties the queue.
//   When the receiver stalls, the result holds in the output register and
//   up to two further items wait in the queue; i_in.ready then drops until
//   the receiver takes the result.
module interval_tick_timer #(
    parameter int COUNTER_WIDTH = itt_pkg::COUNTER_WIDTH_DEF,
    parameter int PRESCALE_DIV  = itt_pkg::PRESCALE_DIV_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itt_in_if.sink    i_in,
    itt_out_if.source o_out
);
    import itt_pkg::*;

    t_cmd w_dec_cmd;   // classified input item
    t_cmd w_q_cmd;     // head of queue
    logic w_q_full;
    logic w_q_valid;
    logic w_pop;

    assign i_in.ready = !w_q_full;

    itt_front u_front (
        .i_kind       (i_in.kind),
        .i_reg_addr   (i_in.reg_addr),
        .i_write_data (i_in.write_data),
        .o_cmd        (w_dec_cmd)
    );

    itt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in.valid && !w_q_full),
        .i_cmd   (w_dec_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    itt_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .PRESCALE_DIV  (PRESCALE_DIV)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_pop),
        .o_out       (o_out)
    );

endmodule
